### rtl/core/mstf_pkg.sv
// Shared types, constants and the note pitch table for the event stream to FM
// register write translator. Used by every module under rtl/core but mstf_queue.
package mstf_pkg;

   localparam int FM_CHANNELS_DEFAULT = 9;
   localparam int CMD_QUEUE_DEPTH     = 4;
   localparam int RSP_QUEUE_DEPTH     = 2;

   // High nibbles of status bytes.
   localparam logic [3:0] STATUS_NOTE_OFF = 4'h8;
   localparam logic [3:0] STATUS_NOTE_ON  = 4'h9;
   localparam logic [3:0] STATUS_PROGRAM  = 4'hC;
   localparam logic [3:0] STATUS_PRESSURE = 4'hD;
   localparam logic [3:0] STATUS_END      = 4'hF;

   // FM register bases and the key-on bit.
   localparam logic [7:0] REG_FNUM_LO = 8'hA0;
   localparam logic [7:0] REG_KEYON   = 8'hB0;
   localparam logic [7:0] KEYON_BIT   = 8'h20;

   localparam logic [63:0] NOTE_NUMERATOR = 64'd461373440;
   localparam logic [63:0] CHIP_CLOCK_DIV = 64'd49716;
   localparam logic [63:0] FNUM_MAX       = 64'd1023;

   localparam logic [63:0] SEMITONE_Q32 [12] = '{
      64'd4294967296, 64'd4550359342, 64'd4820937788, 64'd5107605667,
      64'd5411319705, 64'd5733093519, 64'd6074001000, 64'd6435179895,
      64'd6817835604, 64'd7223245205, 64'd7652761717, 64'd8107818609
   };

   typedef logic [255:0][12:0] pitch_table_type;

   typedef enum logic [1:0] {
      CMD_NONE,
      CMD_NOTE_ON,
      CMD_NOTE_OFF,
      CMD_END
   } cmd_kind_type;

   // One classified event handed from the parser to the write sequencer.
   typedef struct packed {
      cmd_kind_type kind;
      logic [3:0]   ch;
      logic [7:0]   note;
      logic [7:0]   delay;
   } cmd_type;

   typedef struct packed {
      logic       write_valid;
      logic [7:0] reg_addr;
      logic [7:0] reg_data;
      logic [7:0] delay_ticks;
      logic       track_end;
      logic       last;
   } rsp_type;

   // Block and fnum of one note, given octave offset q and semitone k
   // relative to the reference note.
   function automatic logic [12:0] pitch_of(input int q, input int k);
      logic [63:0] x;
      logic [63:0] f;
      int          b;
      int          s;
      logic        done;
      x = (NOTE_NUMERATOR * SEMITONE_Q32[k] + CHIP_CLOCK_DIV / 2) / CHIP_CLOCK_DIV;
      b = 0;
      done = 1'b0;
      for (int i = 0; i < 7; i++) begin
         if (!done && x >= (64'd1 << (42 + b - q))) begin
            b = b + 1;
         end else begin
            done = 1'b1;
         end
      end
      s = 32 + b - q;
      f = (x + (64'd1 << (s - 1))) >> s;
      if (f > FNUM_MAX) begin
         f = FNUM_MAX;
      end
      return {3'(b), f[9:0]};
   endfunction

   function automatic pitch_table_type build_pitch_table();
      pitch_table_type t;
      int              q;
      int              k;
      // Note 0 sits three semitones above a multiple of twelve below note 69.
      q = -6;
      k = 3;
      for (int n = 0; n < 256; n++) begin
         t[n] = pitch_of(q, k);
         if (k == 11) begin
            k = 0;
            q = q + 1;
         end else begin
            k = k + 1;
         end
      end
      return t;
   endfunction

   localparam pitch_table_type PITCH_TABLE = build_pitch_table();

endpackage

### rtl/core/mstf_queue.sv
// Small first-in first-out queue of flat words, built from registers.
// Depends on nothing; the top level sizes it from mstf_pkg constants.
module mstf_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

### rtl/core/mstf_front.sv
// Byte parser: tracks running status and event position, and turns each
// finished event into one command. Depends on mstf_pkg.
module mstf_front #(
   parameter int FM_CHANNELS = mstf_pkg::FM_CHANNELS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [7:0]       data_byte,
   input  logic             track_start,
   input  logic             cmd_full,
   output logic             cmd_push,
   output mstf_pkg::cmd_type cmd
);

   localparam logic [4:0] CH_LIMIT = 5'(FM_CHANNELS);

   logic       accept;
   logic [7:0] status_ff, status_in;
   logic       seen_ff, seen_in;
   logic [1:0] index_ff, index_in;
   logic [7:0] first_ff, first_in;
   logic [7:0] second_ff, second_in;
   logic       ended_ff, ended_in;
   logic [3:0] hi;
   logic       one_data;

   assign accept = push && !cmd_full;
   // Data bytes are only taken without a track start, so the stored status applies.
   assign hi     = status_ff[7:4];

   always_comb begin
      // A track start clears the parser before the byte is looked at.
      status_in = track_start ? '0 : status_ff;
      seen_in   = track_start ? 1'b0 : seen_ff;
      index_in  = track_start ? 2'd0 : index_ff;
      ended_in  = track_start ? 1'b0 : ended_ff;
      first_in  = first_ff;
      second_in = second_ff;
      one_data  = 1'b0;
      cmd_push  = 1'b0;
      cmd       = '0;

      if (!ended_in) begin
         if (index_in == 2'd0 && data_byte[7]) begin
            if (data_byte[7:4] == mstf_pkg::STATUS_END) begin
               ended_in = 1'b1;
               cmd_push = accept;
               cmd.kind = mstf_pkg::CMD_END;
            end else begin
               status_in = data_byte;
               seen_in   = 1'b1;
            end
         end else if (seen_in) begin
            one_data = (hi == mstf_pkg::STATUS_PROGRAM) ||
                       (hi == mstf_pkg::STATUS_PRESSURE);
            if (index_in == 2'd0) begin
               first_in = data_byte;
               index_in = 2'd1;
            end else if (index_in == 2'd1 && !one_data) begin
               second_in = data_byte;
               index_in  = 2'd2;
            end else begin
               // This byte is the delay and closes the event.
               index_in  = 2'd0;
               cmd_push  = accept;
               cmd.ch    = status_in[3:0];
               cmd.note  = first_in;
               cmd.delay = data_byte;
               if ({1'b0, status_in[3:0]} < CH_LIMIT) begin
                  if (hi == mstf_pkg::STATUS_NOTE_ON && second_in != 8'd0) begin
                     cmd.kind = mstf_pkg::CMD_NOTE_ON;
                  end else if (hi == mstf_pkg::STATUS_NOTE_ON ||
                               hi == mstf_pkg::STATUS_NOTE_OFF) begin
                     cmd.kind = mstf_pkg::CMD_NOTE_OFF;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff <= '0;
         seen_ff   <= 1'b0;
         index_ff  <= 2'd0;
         first_ff  <= '0;
         second_ff <= '0;
         ended_ff  <= 1'b0;
      end else if (accept) begin
         status_ff <= status_in;
         seen_ff   <= seen_in;
         index_ff  <= index_in;
         first_ff  <= first_in;
         second_ff <= second_in;
         ended_ff  <= ended_in;
      end
   end

endmodule

### rtl/core/mstf_back.sv
// Write sequencer: takes commands, keeps each channel's pitch and emits the
// FM register writes one result per cycle while a command waits and the result queue has room. Depends on mstf_pkg.
module mstf_back #(
   parameter int FM_CHANNELS = mstf_pkg::FM_CHANNELS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  mstf_pkg::cmd_type cmd,
   input  logic              cmd_empty,
   output logic              cmd_pop,
   input  logic              rsp_full,
   output logic              rsp_push,
   output mstf_pkg::rsp_type rsp
);

   localparam int         CH_W     = (FM_CHANNELS > 1) ? $clog2(FM_CHANNELS) : 1;
   localparam logic [4:0] CH_LIMIT = 5'(FM_CHANNELS);

   logic [12:0]     pitch_ff [FM_CHANNELS];
   logic            phase_ff, phase_in;
   logic            go;
   logic            pitch_we;
   logic [CH_W-1:0] slot;
   logic [12:0]     p_new;
   logic [12:0]     p_old;

   assign go    = !cmd_empty && !rsp_full;
   assign slot  = ({1'b0, cmd.ch} < CH_LIMIT) ? cmd.ch[CH_W-1:0] : '0;
   assign p_new = mstf_pkg::PITCH_TABLE[cmd.note];
   assign p_old = pitch_ff[slot];

   always_comb begin
      rsp      = '0;
      rsp_push = go;
      cmd_pop  = go;
      pitch_we = 1'b0;
      phase_in = phase_ff;
      unique case (cmd.kind)
         mstf_pkg::CMD_END: begin
            rsp.track_end = 1'b1;
            rsp.last      = 1'b1;
         end
         mstf_pkg::CMD_NOTE_OFF: begin
            rsp.write_valid = 1'b1;
            rsp.reg_addr    = mstf_pkg::REG_KEYON | {4'h0, cmd.ch};
            rsp.reg_data    = {3'b000, p_old[12:10], p_old[9:8]};
            rsp.delay_ticks = cmd.delay;
            rsp.last        = 1'b1;
         end
         mstf_pkg::CMD_NOTE_ON: begin
            rsp.write_valid = 1'b1;
            if (!phase_ff) begin
               // First of two writes: fnum low; the item stays at the head.
               rsp.reg_addr = mstf_pkg::REG_FNUM_LO | {4'h0, cmd.ch};
               rsp.reg_data = p_new[7:0];
               cmd_pop      = 1'b0;
               pitch_we     = go;
               phase_in     = go ? 1'b1 : phase_ff;
            end else begin
               rsp.reg_addr    = mstf_pkg::REG_KEYON | {4'h0, cmd.ch};
               rsp.reg_data    = mstf_pkg::KEYON_BIT |
                                 {3'b000, p_new[12:10], p_new[9:8]};
               rsp.delay_ticks = cmd.delay;
               rsp.last        = 1'b1;
               phase_in        = go ? 1'b0 : phase_ff;
            end
         end
         default: begin
            rsp.delay_ticks = cmd.delay;
            rsp.last        = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
         for (int i = 0; i < FM_CHANNELS; i++) begin
            pitch_ff[i] <= '0;
         end
      end else begin
         phase_ff <= phase_in;
         if (pitch_we) begin
            pitch_ff[slot] <= p_new;
         end
      end
   end

endmodule

### rtl/core/midi_stream_to_fm_register_writes.sv
// Event byte stream to FM register writes. A byte is taken every cycle while full is low;
// an event's closing byte queues its command; the write sequencer turns it into results,
// a note-on's second write after its first, one per cycle while the result queue has room,
// so sustained input is one byte per cycle. Synchronous reset empties both queues and
// clears parser state and pitches.
module midi_stream_to_fm_register_writes #(
   parameter int FM_CHANNELS = mstf_pkg::FM_CHANNELS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [7:0] req_data_byte,
   input  logic       req_track_start,
   output logic       empty,
   input  logic       pop,
   output logic       rsp_write_valid,
   output logic [7:0] rsp_reg_addr,
   output logic [7:0] rsp_reg_data,
   output logic [7:0] rsp_delay_ticks,
   output logic       rsp_track_end,
   output logic       rsp_last
);

   localparam int CMD_W = $bits(mstf_pkg::cmd_type);
   localparam int RSP_W = $bits(mstf_pkg::rsp_type);

   mstf_pkg::cmd_type cmd_wr;
   mstf_pkg::cmd_type cmd_rd;
   mstf_pkg::rsp_type rsp_wr;
   mstf_pkg::rsp_type rsp_rd;
   logic              cmd_push;
   logic              cmd_full;
   logic              cmd_pop;
   logic              cmd_empty;
   logic              rsp_push;
   logic              rsp_full;

   assign full = cmd_full;

   mstf_front #(
      .FM_CHANNELS(FM_CHANNELS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .data_byte  (req_data_byte),
      .track_start(req_track_start),
      .cmd_full   (cmd_full),
      .cmd_push   (cmd_push),
      .cmd        (cmd_wr)
   );

   mstf_queue #(
      .WIDTH(CMD_W),
      .DEPTH(mstf_pkg::CMD_QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (cmd_push),
      .wr_data(cmd_wr),
      .full   (cmd_full),
      .pop    (cmd_pop),
      .rd_data(cmd_rd),
      .empty  (cmd_empty)
   );

   mstf_back #(
      .FM_CHANNELS(FM_CHANNELS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd_rd),
      .cmd_empty(cmd_empty),
      .cmd_pop  (cmd_pop),
      .rsp_full (rsp_full),
      .rsp_push (rsp_push),
      .rsp      (rsp_wr)
   );

   mstf_queue #(
      .WIDTH(RSP_W),
      .DEPTH(mstf_pkg::RSP_QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (rsp_push),
      .wr_data(rsp_wr),
      .full   (rsp_full),
      .pop    (pop),
      .rd_data(rsp_rd),
      .empty  (empty)
   );

   assign rsp_write_valid = rsp_rd.write_valid;
   assign rsp_reg_addr    = rsp_rd.reg_addr;
   assign rsp_reg_data    = rsp_rd.reg_data;
   assign rsp_delay_ticks = rsp_rd.delay_ticks;
   assign rsp_track_end   = rsp_rd.track_end;
   assign rsp_last        = rsp_rd.last;

`ifndef SYNTHESIS
   a_reset_empties: assert property (@(posedge clock) reset |=> empty && !full)
      else $error("queues not empty after reset");

   a_no_result_without_cmd: assert property (@(posedge clock) disable iff (reset)
      cmd_empty |-> !rsp_push)
      else $error("result produced with no command waiting");

   a_end_is_alone: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_track_end) |-> (rsp_last && !rsp_write_valid))
      else $error("end-of-track item malformed");

   a_idle_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_write_valid) |-> (rsp_reg_addr == 8'd0 && rsp_reg_data == 8'd0))
      else $error("register fields set on an item without a write");
`endif

endmodule

### bench/midi_stream_to_fm_register_writes_test.sv
// Self-checking bench for midi_stream_to_fm_register_writes: event bytes in, FM
// register writes out, each checked against an in-bench parser and pitch model.
// Depends on mstf_pkg for status nibbles and register bases.
`timescale 1ns / 1ps

module midi_stream_to_fm_register_writes_test;

   localparam int          FM_CHANNELS     = mstf_pkg::FM_CHANNELS_DEFAULT;
   localparam int          RANDOM_ITEMS    = 1100;
   localparam int          DRAIN_CYCLES    = 16;
   localparam int          CYCLE_LIMIT     = 300000;
   localparam logic [3:0]  STATUS_AFTERTOUCH = 4'hA;
   localparam logic [3:0]  STATUS_CONTROL    = 4'hB;
   localparam logic [3:0]  STATUS_PITCH_BEND = 4'hE;

   // Chip clock scaling for the fnum: 440 * 2^20, and the chip sample rate.
   localparam longint unsigned A440_SCALED = 64'd461373440;
   localparam longint unsigned CHIP_RATE   = 64'd49716;
   localparam longint unsigned FNUM_LIMIT  = 64'd1023;
   localparam longint unsigned SEMITONE_RATIO [12] = '{
      64'd4294967296, 64'd4550359342, 64'd4820937788, 64'd5107605667,
      64'd5411319705, 64'd5733093519, 64'd6074001000, 64'd6435179895,
      64'd6817835604, 64'd7223245205, 64'd7652761717, 64'd8107818609
   };

   typedef struct packed {
      logic [7:0] data;
      logic       start;
   } stream_item_type;

   typedef struct packed {
      logic       write_valid;
      logic [7:0] reg_addr;
      logic [7:0] reg_data;
      logic [7:0] delay_ticks;
      logic       track_end;
      logic       last;
   } fm_write_type;

   typedef enum {RX_READY, RX_PATTERN, RX_COIN, RX_SLOW} rx_mode_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       push = 1'b0;
   logic       pop = 1'b0;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_track_start = 1'b0;
   logic       full;
   logic       empty;
   logic       rsp_write_valid;
   logic [7:0] rsp_reg_addr;
   logic [7:0] rsp_reg_data;
   logic [7:0] rsp_delay_ticks;
   logic       rsp_track_end;
   logic       rsp_last;

   stream_item_type pending_bytes[$];
   fm_write_type    expected_writes[$];
   logic            req_taken = 1'b0;
   int              mismatches = 0;
   int              cycle_count = 0;

   // Parser copy kept by the bench.
   logic [7:0]  cur_status = 8'h00;
   logic        status_valid = 1'b0;
   logic [1:0]  byte_pos = 2'd0;
   logic [7:0]  note_byte = 8'h00;
   logic [7:0]  vel_byte = 8'h00;
   logic        track_done = 1'b0;
   logic [12:0] chan_pitch [FM_CHANNELS];

   int          burst_left = 0;
   int          gap_left = 0;
   rx_mode_type rx_mode = RX_READY;
   int          mode_left = 0;
   logic [11:0] stall_pattern = 12'b1011_0010_0111;

   midi_stream_to_fm_register_writes u_top (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_data_byte   (req_data_byte),
      .req_track_start (req_track_start),
      .empty           (empty),
      .pop             (pop),
      .rsp_write_valid (rsp_write_valid),
      .rsp_reg_addr    (rsp_reg_addr),
      .rsp_reg_data    (rsp_reg_data),
      .rsp_delay_ticks (rsp_delay_ticks),
      .rsp_track_end   (rsp_track_end),
      .rsp_last        (rsp_last)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Block number and fnum of a note; the octave offset is taken relative to A440.
   function automatic logic [12:0] note_to_block_fnum(input logic [7:0] note);
      int              semis;
      int              octave;
      int              step;
      int              blk;
      int              shift;
      longint unsigned scaled;
      longint unsigned fnum;
      semis  = int'(note) + 3;
      octave = semis / 12 - 6;
      step   = semis % 12;
      scaled = (A440_SCALED * SEMITONE_RATIO[step] + CHIP_RATE / 2) / CHIP_RATE;
      blk = 0;
      while (blk < 7 && scaled >= (64'd1 << (42 + blk - octave))) begin
         blk++;
      end
      shift = 32 + blk - octave;
      fnum  = (scaled + (64'd1 << (shift - 1))) >> shift;
      if (fnum > FNUM_LIMIT) begin
         fnum = FNUM_LIMIT;
      end
      return {3'(blk), fnum[9:0]};
   endfunction

   task automatic predict_writes(input logic [7:0] in_data, input logic in_start);
      logic [3:0]  hi_nib;
      logic [3:0]  chan;
      logic        single_data;
      logic [12:0] pitch;
      if (in_start) begin
         cur_status   = 8'h00;
         status_valid = 1'b0;
         byte_pos     = 2'd0;
         track_done   = 1'b0;
      end
      if (track_done) begin
         return;
      end
      if (byte_pos == 2'd0 && in_data[7]) begin
         if (in_data[7:4] == mstf_pkg::STATUS_END) begin
            track_done = 1'b1;
            expected_writes.push_back(fm_write_type'{1'b0, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1});
         end else begin
            cur_status   = in_data;
            status_valid = 1'b1;
         end
         return;
      end
      if (!status_valid) begin
         return;
      end
      hi_nib      = cur_status[7:4];
      single_data = (hi_nib == mstf_pkg::STATUS_PROGRAM) ||
                    (hi_nib == mstf_pkg::STATUS_PRESSURE);
      if (byte_pos == 2'd0) begin
         note_byte = in_data;
         byte_pos  = 2'd1;
         return;
      end
      if (byte_pos == 2'd1 && !single_data) begin
         vel_byte = in_data;
         byte_pos = 2'd2;
         return;
      end
      // This byte is the event's delay.
      byte_pos = 2'd0;
      chan     = cur_status[3:0];
      if (chan < FM_CHANNELS) begin
         if (hi_nib == mstf_pkg::STATUS_NOTE_ON && vel_byte != 8'h00) begin
            pitch            = note_to_block_fnum(note_byte);
            chan_pitch[chan] = pitch;
            expected_writes.push_back(fm_write_type'{1'b1, mstf_pkg::REG_FNUM_LO + 8'(chan),
               pitch[7:0], 8'h00, 1'b0, 1'b0});
            expected_writes.push_back(fm_write_type'{1'b1, mstf_pkg::REG_KEYON + 8'(chan),
               mstf_pkg::KEYON_BIT | {3'b000, pitch[12:10], pitch[9:8]}, in_data, 1'b0,
               1'b1});
            return;
         end
         if (hi_nib == mstf_pkg::STATUS_NOTE_OFF || hi_nib == mstf_pkg::STATUS_NOTE_ON) begin
            pitch = chan_pitch[chan];
            expected_writes.push_back(fm_write_type'{1'b1, mstf_pkg::REG_KEYON + 8'(chan),
               {3'b000, pitch[12:10], pitch[9:8]}, in_data, 1'b0, 1'b1});
            return;
         end
      end
      expected_writes.push_back(fm_write_type'{1'b0, 8'h00, 8'h00, in_data, 1'b0, 1'b1});
   endtask

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%02h, got 0x%02h", name, want, got);
         mismatches++;
      end
   endtask

   function automatic void queue_byte(input logic [7:0] data, input logic start);
      pending_bytes.push_back(stream_item_type'{data, start});
   endfunction

   function automatic void queue_directed_traffic();
      queue_byte(8'h45, 1'b0);               // data with no status yet: dropped
      queue_byte({mstf_pkg::STATUS_NOTE_ON, 4'h0}, 1'b1);
      queue_byte(8'd69, 1'b0);
      queue_byte(8'h7F, 1'b0);
      queue_byte(8'h00, 1'b0);
      // Running status on the highest reachable note, velocity and delay above 0x7F.
      queue_byte(8'h7F, 1'b0);
      queue_byte(8'h80, 1'b0);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'h00, 1'b0);               // lowest note
      queue_byte(8'h01, 1'b0);
      queue_byte(8'hF3, 1'b0);
      // Key-off on the top channel before it has ever had a pitch.
      queue_byte({mstf_pkg::STATUS_NOTE_OFF, 4'(FM_CHANNELS - 1)}, 1'b0);
      queue_byte(8'h3C, 1'b0);
      queue_byte(8'h40, 1'b0);
      queue_byte(8'h05, 1'b0);
      queue_byte({mstf_pkg::STATUS_NOTE_ON, 4'h0}, 1'b0);
      queue_byte(8'd69, 1'b0);
      queue_byte(8'h00, 1'b0);               // zero velocity acts as key-off
      queue_byte(8'h07, 1'b0);
      queue_byte({mstf_pkg::STATUS_NOTE_ON, 4'hF}, 1'b0);   // channel beyond the chip
      queue_byte(8'h3C, 1'b0);
      queue_byte(8'h64, 1'b0);
      queue_byte(8'h03, 1'b0);
      queue_byte({mstf_pkg::STATUS_PROGRAM, 4'h3}, 1'b0);
      queue_byte(8'h05, 1'b0);
      queue_byte(8'h10, 1'b0);
      queue_byte({mstf_pkg::STATUS_PRESSURE, 4'h1}, 1'b0);
      queue_byte(8'h7F, 1'b0);
      queue_byte(8'h00, 1'b0);
      queue_byte({STATUS_AFTERTOUCH, 4'h2}, 1'b0);
      queue_byte(8'h10, 1'b0);
      queue_byte(8'h20, 1'b0);
      queue_byte(8'h30, 1'b0);
      queue_byte({STATUS_CONTROL, 4'h4}, 1'b0);
      queue_byte(8'h07, 1'b0);
      queue_byte(8'h64, 1'b0);
      queue_byte(8'h01, 1'b0);
      queue_byte({STATUS_PITCH_BEND, 4'h5}, 1'b0);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'h40, 1'b0);
      queue_byte(8'h02, 1'b0);
      queue_byte({mstf_pkg::STATUS_END, 4'h7}, 1'b0);
      queue_byte({mstf_pkg::STATUS_NOTE_ON, 4'h0}, 1'b0);   // after the end: dropped
      queue_byte(8'h3C, 1'b1);               // new track, but no status yet
   endfunction

   // Mostly well-formed events with random content, plus stray bytes, cut-off
   // events and track ends followed by bytes that must be dropped.
   function automatic void queue_random_traffic();
      int         live_items;
      int         roll;
      int         pick;
      logic       need_start;
      logic       have_status;
      logic       single_data;
      logic [3:0] hi_nib;
      logic [3:0] chan;
      logic [7:0] status_byte;
      live_items  = 0;
      need_start  = 1'b1;
      have_status = 1'b0;
      status_byte = 8'h00;
      while (live_items < RANDOM_ITEMS) begin
         roll = $urandom_range(0, 99);
         if (roll < 3) begin
            queue_byte({mstf_pkg::STATUS_END, 4'($urandom_range(0, 15))}, need_start);
            live_items++;
            repeat ($urandom_range(0, 3)) queue_byte(8'($urandom_range(0, 255)), 1'b0);
            need_start  = 1'b1;
            have_status = 1'b0;
         end else if (roll < 10) begin
            queue_byte(8'($urandom_range(0, 239)), $urandom_range(0, 3) == 0);
            live_items++;
            have_status = 1'b0;
            if ($urandom_range(0, 1) == 1) begin
               need_start = 1'b1;
            end
         end else begin
            if (!have_status || need_start || $urandom_range(0, 2) == 0) begin
               pick = $urandom_range(0, 9);
               case (pick)
                  0, 1, 2, 3: hi_nib = mstf_pkg::STATUS_NOTE_ON;
                  4, 5:       hi_nib = mstf_pkg::STATUS_NOTE_OFF;
                  6:          hi_nib = mstf_pkg::STATUS_PROGRAM;
                  7:          hi_nib = mstf_pkg::STATUS_PRESSURE;
                  8:          hi_nib = STATUS_AFTERTOUCH;
                  default:    hi_nib = ($urandom_range(0, 1) == 0) ? STATUS_CONTROL
                                                                  : STATUS_PITCH_BEND;
               endcase
               chan = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, FM_CHANNELS - 1))
                                                : 4'($urandom_range(FM_CHANNELS, 15));
               status_byte = {hi_nib, chan};
               queue_byte(status_byte, need_start);
               live_items++;
               need_start  = 1'b0;
               have_status = 1'b1;
            end
            single_data = (status_byte[7:4] == mstf_pkg::STATUS_PROGRAM) ||
                          (status_byte[7:4] == mstf_pkg::STATUS_PRESSURE);
            queue_byte(8'($urandom_range(0, 255)), 1'b0);
            live_items++;
            if (!single_data) begin
               queue_byte(($urandom_range(0, 4) == 0) ? 8'h00 : 8'($urandom_range(0, 255)),
                          1'b0);
               live_items++;
            end
            // Now and then the delay byte is left out.
            if ($urandom_range(0, 19) != 0) begin
               queue_byte(8'($urandom_range(0, 255)), 1'b0);
               live_items++;
            end
         end
      end
   endfunction

   // Sender: bursts of items separated by idle gaps.
   always @(negedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push && req_taken) begin
            void'(pending_bytes.pop_front());
         end
         if (!push || req_taken) begin
            if (burst_left == 0) begin
               burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 20);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 :
                            (($urandom_range(0, 9) == 0) ? 20 : $urandom_range(1, 4));
            end
            if (gap_left > 0 || pending_bytes.size() == 0) begin
               if (gap_left > 0) begin
                  gap_left--;
               end
               push <= 1'b0;
            end else begin
               push            <= 1'b1;
               req_data_byte   <= pending_bytes[0].data;
               req_track_start <= pending_bytes[0].start;
               burst_left--;
            end
         end
      end
   end

   // Receiver: switches among always ready, a rotating stall pattern, coin
   // flips and a mostly stalled mode.
   always @(negedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            rx_mode   = rx_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 200);
         end
         mode_left--;
         stall_pattern = {stall_pattern[10:0], stall_pattern[11]};
         case (rx_mode)
            RX_READY:   pop <= 1'b1;
            RX_PATTERN: pop <= stall_pattern[0];
            RX_COIN:    pop <= ($urandom_range(0, 1) == 1);
            default:    pop <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   always @(posedge clock) begin : monitor
      fm_write_type want;
      req_taken <= !reset && push && !full;
      if (!reset) begin
         if (pop && !empty) begin
            if (expected_writes.size() == 0) begin
               $error("result with no item waiting: addr 0x%02h data 0x%02h",
                      rsp_reg_addr, rsp_reg_data);
               mismatches++;
            end else begin
               want = expected_writes.pop_front();
               check_field("write_valid", 8'(want.write_valid), 8'(rsp_write_valid));
               check_field("reg_addr", want.reg_addr, rsp_reg_addr);
               check_field("reg_data", want.reg_data, rsp_reg_data);
               check_field("delay_ticks", want.delay_ticks, rsp_delay_ticks);
               check_field("track_end", 8'(want.track_end), 8'(rsp_track_end));
               check_field("last", 8'(want.last), 8'(rsp_last));
            end
         end
         if (push && !full) begin
            predict_writes(req_data_byte, req_track_start);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("midi_stream_to_fm_register_writes verification failed");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < FM_CHANNELS; i++) begin
         chan_pitch[i] = 13'd0;
      end
      queue_directed_traffic();
      queue_random_traffic();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (pending_bytes.size() != 0 || push) begin
         @(posedge clock);
      end
      while (expected_writes.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("midi_stream_to_fm_register_writes verification clean");
      end else begin
         $display("midi_stream_to_fm_register_writes verification failed");
      end
      $finish;
   end

endmodule
